// File: hdl/utc_pkg.sv
// shared types and constants for the transmit ring chunker
`timescale 1ns / 1ps
`default_nettype none

package utc_pkg;

   // operation codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_POLL    = 2'd2;

   // register indexes
   localparam logic CSR_SEVEN_BIT = 1'b0;
   localparam logic CSR_MAX_CHUNK = 1'b1;

   localparam logic [8:0] CHUNK_MIN      = 9'd16;
   localparam logic [8:0] CHUNK_MAX      = 9'd256;
   localparam logic [7:0] SEVEN_BIT_MASK = 8'h7f;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       last_in_call;
   } req_type;

   typedef struct packed {
      logic       write_accepted;
      logic       byte_valid;
      logic [7:0] tx_byte;
      logic       chunk_last;
      logic       chunk_started;
      logic [8:0] chunk_length;
      logic [8:0] free_space;
      logic       busy_res;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/utc_core.sv
// ring pointers, chunk tracking and ring memory with the first result stage
`timescale 1ns / 1ps
`default_nettype none

module utc_core
   import utc_pkg::*;
#(
   parameter int RING_LEN = 512
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire req_type    req,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_wdata,
   output rsp_type         s1_rsp
);

   localparam int IW = $clog2(RING_LEN);
   localparam int CW = IW + 1;
   localparam int SW = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0] LEN_C    = CW'(RING_LEN);
   localparam logic [IW-1:0] LAST_IDX = IW'(RING_LEN - 1);

   logic [7:0] ring_mem [RING_LEN];

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic          busy_ff, busy_in;
   logic [8:0]    size_ff, size_in;
   logic [8:0]    sent_ff, sent_in;
   logic          done_ff, done_in;
   logic          mode_ff, mode_in;
   logic [8:0]    cap_ff, cap_in;
   rsp_type       s1_ff, s1_in;
   logic [7:0]    rd_ff;

   logic [IW-1:0] head_mid, tail_mid, head_inc;
   logic          busy_mid, attempt, start, wrapped, has_room, byte_out, last_out;
   logic [CW-1:0] free_now, free_mid, chunk_end, chunk_span, retire_sum;
   logic [SW-1:0] span_ext, read_sum;
   logic [8:0]    chunk_len, sent_inc;
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   always_comb begin
      free_now = (head_ff >= tail_ff) ? (LEN_C - CW'(1) - (CW'(head_ff) - CW'(tail_ff)))
                                      : (CW'(tail_ff) - CW'(head_ff) - CW'(1));
      has_room = (free_now != '0);
      wrapped  = (head_ff == LAST_IDX);
      head_inc = wrapped ? '0 : head_ff + IW'(1);
      sent_inc = sent_ff + 9'd1;
      read_sum = SW'(tail_ff) + SW'(sent_ff);
      retire_sum = CW'(tail_ff) + CW'(size_ff);

      head_mid = head_ff;
      tail_mid = tail_ff;
      busy_mid = busy_ff;
      size_in  = size_ff;
      sent_in  = sent_ff;
      done_in  = done_ff;
      attempt  = 1'b0;
      byte_out = 1'b0;
      last_out = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_waddr = head_ff;
      mem_wdata = mode_ff ? (req.data_byte & SEVEN_BIT_MASK) : req.data_byte;
      mem_raddr = IW'(read_sum);

      case (req.op)
         OP_WRITE: begin
            if (has_room) begin
               mem_we   = accept;
               head_mid = head_inc;
            end
         end
         OP_REQUEST: begin
            if (busy_ff && (sent_ff < size_ff)) begin
               byte_out = 1'b1;
               mem_re   = accept;
               sent_in  = sent_inc;
               if (sent_inc == size_ff) begin
                  last_out = 1'b1;
                  done_in  = 1'b1;
               end
            end
         end
         OP_POLL: begin
            if (done_ff) begin
               tail_mid = (retire_sum >= LEN_C) ? '0 : IW'(retire_sum);
               busy_mid = 1'b0;
               size_in  = '0;
               sent_in  = '0;
               done_in  = 1'b0;
            end
            attempt = 1'b1;
         end
         default: begin
         end
      endcase

      free_mid = (head_mid >= tail_mid)
                    ? (LEN_C - CW'(1) - (CW'(head_mid) - CW'(tail_mid)))
                    : (CW'(tail_mid) - CW'(head_mid) - CW'(1));
      if (req.op == OP_WRITE && has_room)
         attempt = req.last_in_call || wrapped || (free_mid == '0);

      // chunk runs to the head or to the physical end of the ring
      chunk_end  = (head_mid <= tail_mid) ? LEN_C : CW'(head_mid);
      chunk_span = chunk_end - CW'(tail_mid);
      span_ext   = SW'(chunk_span);
      chunk_len  = (span_ext > SW'(cap_ff)) ? cap_ff : 9'(span_ext);
      start      = attempt && !busy_mid && (head_mid != tail_mid);

      busy_in = busy_mid;
      if (start) begin
         busy_in = 1'b1;
         size_in = chunk_len;
         sent_in = '0;
         done_in = 1'b0;
      end
      head_in = head_mid;
      tail_in = tail_mid;

      s1_in.write_accepted = (req.op == OP_WRITE) && has_room;
      s1_in.byte_valid     = byte_out;
      s1_in.tx_byte        = '0;
      s1_in.chunk_last     = last_out;
      s1_in.chunk_started  = start;
      s1_in.chunk_length   = busy_in ? size_in : 9'd0;
      s1_in.free_space     = 9'(free_mid);
      s1_in.busy_res       = busy_in;

      mode_in = mode_ff;
      cap_in  = cap_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEVEN_BIT: mode_in = csr_wdata[0];
            CSR_MAX_CHUNK: begin
               if (csr_wdata < CHUNK_MIN)
                  cap_in = CHUNK_MIN;
               else if (csr_wdata > CHUNK_MAX)
                  cap_in = CHUNK_MAX;
               else
                  cap_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         busy_ff <= 1'b0;
         size_ff <= '0;
         sent_ff <= '0;
         done_ff <= 1'b0;
         mode_ff <= 1'b0;
         cap_ff  <= CHUNK_MIN;
      end else begin
         mode_ff <= mode_in;
         cap_ff  <= cap_in;
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            busy_ff <= busy_in;
            size_ff <= size_in;
            sent_ff <= sent_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         s1_ff <= s1_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         ring_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re)
         rd_ff <= ring_mem[mem_raddr];
   end

   always_comb begin
      s1_rsp         = s1_ff;
      s1_rsp.tx_byte = s1_ff.byte_valid ? rd_ff : 8'd0;
   end

endmodule

`default_nettype wire

// File: hdl/uart_tx_ring_dma_chunker.sv
// top level of the transmit ring buffer with chunked sender interface
`timescale 1ns / 1ps
`default_nettype none

// Transmit ring of RING_LEN bytes (at most RING_LEN-1 queued) that hands its
// contents to a sender in contiguous chunks of up to max_chunk bytes. Each
// transfer on req_ is a byte write, a sender byte request or a poll, and
// produces exactly one transfer on rsp_. One item is taken per clock cycle
// while req_stall is low; a result passes the registered read of the ring
// memory and the first result stage, then the output register, which lets
// a new item enter while a result waits under rsp_stall. Configuration
// writes on csr_ take effect at once and belong to idle periods. Ring memory
// contents are not cleared after reset; only written entries are ever sent.

module uart_tx_ring_dma_chunker
   import utc_pkg::*;
#(
   parameter int RING_LEN = 512
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_wdata
);

   logic    s1_vld_ff, s1_vld_in;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff;
   rsp_type s1_rsp;
   logic    s1_move, accept;

   utc_core #(
      .RING_LEN (RING_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .s1_rsp    (s1_rsp)
   );

   always_comb begin
      s1_move    = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
      req_stall  = s1_vld_ff && !s1_move;
      accept     = req_valid && !req_stall;
      s1_vld_in  = accept || (s1_vld_ff && !s1_move);
      rsp_vld_in = s1_move || (rsp_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move)
         rsp_ff <= s1_rsp;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/utc_checker.sv
// port checks on the result channel of the transmit ring chunker
`timescale 1ns / 1ps
`default_nettype none

module utc_checker
   import utc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.write_accepted && rsp_data.byte_valid))
      else $error("write and byte in the same result");

   a_last_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_last |-> rsp_data.byte_valid && rsp_data.busy_res)
      else $error("chunk end without a byte");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_started |->
         rsp_data.busy_res && rsp_data.chunk_length != 9'd0)
      else $error("chunk started but not in flight");

   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |->
         rsp_data.chunk_length == 9'd0 && !rsp_data.byte_valid)
      else $error("idle result shows chunk activity");

endmodule

bind uart_tx_ring_dma_chunker utc_checker u_utc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: dv/uart_tx_ring_dma_chunker_tb.sv
// self-checking testbench for the transmit ring chunker: predictor, driver, monitor, phases
`timescale 1ns / 1ps

module uart_tx_ring_dma_chunker_tb;
   import utc_pkg::*;

   localparam int RING       = 512;
   localparam int DRAIN_WAIT = 6;
   localparam int HOLD_LEN   = 300;
   localparam int STUCK_MAX  = 5000;

   // op value with no function in the block
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we    = 1'b0;
   logic       csr_index = 1'b0;
   logic [8:0] csr_wdata = '0;

   uart_tx_ring_dma_chunker #(.RING_LEN(RING)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ring predictor state
   logic [7:0] ring_mem [RING];
   int         head_ptr     = 0;
   int         tail_ptr     = 0;
   int         chunk_len    = 0;
   int         chunk_pulled = 0;
   bit         chunk_busy   = 1'b0;
   bit         chunk_done   = 1'b0;
   bit         mask_seven   = 1'b0;
   logic [8:0] chunk_cap    = CHUNK_MIN;

   int n_starts  = 0;
   int n_at_end  = 0;
   int n_drops   = 0;
   int n_wraps   = 0;
   int n_sent    = 0;
   int n_checked = 0;
   int n_errors  = 0;

   req_type pending_q [$];
   rsp_type expected_q [$];

   bit idle_on  = 1'b0;
   int hold_ask = 0;

   function automatic int ring_free();
      if (head_ptr >= tail_ptr) return RING - (head_ptr - tail_ptr) - 1;
      return tail_ptr - head_ptr - 1;
   endfunction

   // room from the head up to the tail or the wrap point
   function automatic int room_ahead();
      if (head_ptr < tail_ptr) return tail_ptr - head_ptr - 1;
      if (tail_ptr != 0) return RING - head_ptr;
      return RING - 1 - head_ptr;
   endfunction

   function automatic bit launch_chunk();
      int stop;
      int len;
      int cap;
      if (chunk_busy || head_ptr == tail_ptr) return 1'b0;
      stop = head_ptr;
      if (stop <= tail_ptr) stop = RING;
      len = stop - tail_ptr;
      cap = chunk_cap;
      if (cap < CHUNK_MIN) cap = CHUNK_MIN;
      if (cap > CHUNK_MAX) cap = CHUNK_MAX;
      if (len > cap) len = cap;
      else if (stop == RING) n_at_end++;
      chunk_len    = len;
      chunk_pulled = 0;
      chunk_done   = 1'b0;
      chunk_busy   = 1'b1;
      n_starts++;
      return 1'b1;
   endfunction

   function automatic rsp_type ring_step(req_type it);
      rsp_type    r;
      logic [7:0] b;
      bit         wrapped;
      int         t;
      r       = '0;
      wrapped = 1'b0;
      case (it.op)
         OP_WRITE: begin
            if (room_ahead() != 0) begin
               b = it.data_byte;
               if (mask_seven) b = b & SEVEN_BIT_MASK;
               ring_mem[head_ptr] = b;
               head_ptr++;
               if (head_ptr >= RING) begin
                  head_ptr = 0;
                  wrapped  = 1'b1;
                  n_wraps++;
               end
               r.write_accepted = 1'b1;
               if (it.last_in_call || wrapped || ring_free() == 0)
                  r.chunk_started = launch_chunk();
            end else begin
               n_drops++;
            end
         end
         OP_REQUEST: begin
            if (chunk_busy && chunk_pulled < chunk_len) begin
               r.tx_byte    = ring_mem[(tail_ptr + chunk_pulled) % RING];
               r.byte_valid = 1'b1;
               chunk_pulled++;
               if (chunk_pulled == chunk_len) begin
                  r.chunk_last = 1'b1;
                  chunk_done   = 1'b1;
               end
            end
         end
         OP_POLL: begin
            if (chunk_done) begin
               t = tail_ptr + chunk_len;
               if (t >= RING) t = 0;
               tail_ptr     = t;
               chunk_len    = 0;
               chunk_pulled = 0;
               chunk_busy   = 1'b0;
               chunk_done   = 1'b0;
            end
            r.chunk_started = launch_chunk();
         end
         default: ;
      endcase
      r.chunk_length = chunk_busy ? 9'(chunk_len) : 9'd0;
      r.free_space   = 9'(ring_free());
      r.busy_res     = chunk_busy;
      return r;
   endfunction

   task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         n_errors++;
      end
   endtask

   // driver: one transfer per accepted item, gaps only between transfers
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_q.push_back(ring_step(req_data));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares every result transfer and drives the stall side
   int stall_left = 0;
   int hold_left  = 0;
   int hold_seen  = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (expected_q.size() == 0) begin
               $display("%0t: result with no expectation waiting, expected none, actual %h",
                        $time, rsp_data);
               n_errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("write_accepted", 9'(want.write_accepted),
                           9'(rsp_data.write_accepted));
               check_field("byte_valid", 9'(want.byte_valid), 9'(rsp_data.byte_valid));
               check_field("tx_byte", 9'(want.tx_byte), 9'(rsp_data.tx_byte));
               check_field("chunk_last", 9'(want.chunk_last), 9'(rsp_data.chunk_last));
               check_field("chunk_started", 9'(want.chunk_started),
                           9'(rsp_data.chunk_started));
               check_field("chunk_length", want.chunk_length, rsp_data.chunk_length);
               check_field("free_space", want.free_space, rsp_data.free_space);
               check_field("busy_res", 9'(want.busy_res), 9'(rsp_data.busy_res));
            end
         end
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_MAX) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck = 0;
         else
            stuck++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic csr_write(logic idx, logic [8:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_regs(bit seven, logic [8:0] cap);
      csr_write(CSR_SEVEN_BIT, {8'($urandom), seven});
      mask_seven = seven;
      csr_write(CSR_MAX_CHUNK, cap);
      chunk_cap = cap;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic push_item(logic [1:0] op, logic [7:0] d, logic last);
      req_type it;
      it.op           = op;
      it.data_byte    = d;
      it.last_in_call = last;
      pending_q.push_back(it);
   endtask

   // random mix of all ops, weights in percent, op spare takes the rest
   task automatic queue_mix(int count, int w_write, int w_req, int w_poll, int last_odds);
      int         pick;
      logic [1:0] op;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < w_write) op = OP_WRITE;
         else if (pick < w_write + w_req) op = OP_REQUEST;
         else if (pick < w_write + w_req + w_poll) op = OP_POLL;
         else op = OP_SPARE;
         push_item(op, 8'($urandom), $urandom_range(0, last_odds - 1) == 0);
      end
   endtask

   // long runs of writes fill the ring, wrap the head and hit drops
   task automatic queue_flood(int count);
      repeat (count) push_item(OP_WRITE, 8'($urandom), $urandom_range(0, 15) == 0);
   endtask

   // sender sessions: poll, then a run of pulls with a little write noise
   task automatic queue_drain(int count);
      int done;
      int pulls;
      done = 0;
      while (done < count) begin
         push_item(OP_POLL, 8'($urandom), 1'($urandom));
         pulls = $urandom_range(1, 40);
         repeat (pulls) begin
            if ($urandom_range(0, 9) == 0)
               push_item(OP_WRITE, 8'($urandom), $urandom_range(0, 3) == 0);
            else
               push_item(OP_REQUEST, 8'($urandom), 1'($urandom));
         end
         done += pulls + 1;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: idle ring, small chunk, early poll, pulls past the end, spare op
      set_regs(1'b0, CHUNK_MIN);
      push_item(OP_REQUEST, 8'h00, 1'b0);
      push_item(OP_POLL, 8'h00, 1'b0);
      push_item(OP_SPARE, 8'hff, 1'b1);
      push_item(OP_WRITE, 8'hff, 1'b0);
      push_item(OP_WRITE, 8'h00, 1'b0);
      push_item(OP_WRITE, 8'ha5, 1'b1);
      push_item(OP_WRITE, 8'h80, 1'b1);
      push_item(OP_POLL, 8'h00, 1'b0);
      repeat (3) push_item(OP_REQUEST, 8'h00, 1'b0);
      push_item(OP_REQUEST, 8'hff, 1'b1);
      push_item(OP_WRITE, 8'h5a, 1'b0);
      push_item(OP_POLL, 8'h00, 1'b0);
      push_item(OP_POLL, 8'hff, 1'b1);
      repeat (2) push_item(OP_REQUEST, 8'h00, 1'b0);
      push_item(OP_SPARE, 8'h00, 1'b0);
      push_item(OP_POLL, 8'h00, 1'b0);
      push_item(OP_REQUEST, 8'h00, 1'b0);
      wait_drained();

      // mixed traffic with a long receiver hold-off at the start
      set_regs(1'b1, CHUNK_MAX);
      idle_on <= 1'b1;
      queue_mix(40, 55, 30, 12, 6);
      hold_ask <= hold_ask + 1;
      wait_drained();

      set_regs(1'b0, 9'h1ff);
      queue_flood(520);
      wait_drained();

      set_regs(1'b1, CHUNK_MAX + 9'd1);
      queue_drain(80);
      wait_drained();

      set_regs(1'b0, 9'd0);
      queue_mix(30, 45, 40, 12, 4);
      wait_drained();

      // closing stretch without idling on either side
      idle_on <= 1'b0;
      set_regs(1'b1, 9'($urandom_range(CHUNK_MIN, CHUNK_MAX)));
      queue_mix(50, 45, 40, 12, 4);
      wait_drained();

      $display("sent %0d items and checked %0d results over six register settings",
               n_sent, n_checked);
      $display("chunks started %0d (%0d ending at the ring end), drops %0d, head wraps %0d",
               n_starts, n_at_end, n_drops, n_wraps);
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
hdl/utc_pkg.sv
hdl/utc_core.sv
hdl/uart_tx_ring_dma_chunker.sv
hdl/utc_checker.sv
dv/uart_tx_ring_dma_chunker_tb.sv
